// File: hw/rtl/adp_pkg.sv
// Shared types and constants for the Art-Net ArtDmx packet parser.
`default_nettype none
package adp_pkg;

  localparam int unsigned PosW        = 11;
  localparam logic [PosW-1:0] PosMax  = 11'd2047;
  localparam logic [PosW-1:0] DataOffset = 11'd18;
  localparam logic [15:0] MaxChannels = 16'd512;
  localparam logic [15:0] OpDmx       = 16'h5000;
  localparam logic [15:0] OpPoll      = 16'h2000;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [8:0]  channel;
    logic [7:0]  channel_value;
    logic        packet_done;
    logic [15:0] opcode;
    logic [15:0] universe;
    logic [7:0]  sequence_res;
    logic [15:0] data_length;
    logic [2:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    ST_DMX       = 3'd0,
    ST_ID_BAD    = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_POLL      = 3'd3,
    ST_OTHER_OP  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    FLD_NONE   = 4'd0,
    FLD_ID     = 4'd1,
    FLD_OP_LO  = 4'd2,
    FLD_OP_HI  = 4'd3,
    FLD_SEQ    = 4'd4,
    FLD_UNI_LO = 4'd5,
    FLD_UNI_HI = 4'd6,
    FLD_LEN_HI = 4'd7,
    FLD_LEN_LO = 4'd8,
    FLD_DATA   = 4'd9
  } field_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    field_t          field;
    logic [7:0]      value;
    logic            id_ok;
    logic [PosW-1:0] data_idx;
    logic            pos_lt9;
    logic            pos_lt17;
    logic            last;
  } cmd_t;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h41;
      3'd1: b = 8'h72;
      3'd2: b = 8'h74;
      3'd3: b = 8'h2d;
      3'd4: b = 8'h4e;
      3'd5: b = 8'h65;
      3'd6: b = 8'h74;
      3'd7: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/artnet_dmx_packet_parser.sv
// Art-Net ArtDmx packet parser: top level.
//
// The item channel takes one UDP payload byte per beat, with last_byte set on
// the final byte of each packet. The result channel gives a beat for each DMX
// channel write (data bytes from offset 18 of an ArtDmx packet whose length is
// 1..512, only those below the stated length) and one beat on the last byte
// carrying the packet summary; a write on the last byte shares that beat.
// Bytes that produce neither give no beat.
// Throughput: one byte per cycle sustained while result_ready stays high. A
// result passes through the queue entry, written at the accepting edge, and
// then the back-end output register, written when the back end pops it.
// The queue of DEPTH entries decouples the two sides: when the receiver stalls
// the back end holds its output register, the queue fills, and item_ready
// drops once DEPTH bytes are waiting.
// Reset clears the byte position, the queue and the output valid; the next
// byte accepted is taken as byte 0 of a packet.
`default_nettype none
module artnet_dmx_packet_parser #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire adp_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output adp_pkg::result_t      result
);

  adp_pkg::cmd_t front_cmd;
  adp_pkg::cmd_t back_cmd;
  logic          front_valid;
  logic          front_ready;
  logic          back_valid;
  logic          back_ready;

  adp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  adp_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  adp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (back_valid),
    .cmd_ready    (back_ready),
    .cmd          (back_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// File: hw/rtl/adp_front.sv
// Front end: byte position tracking and per-byte field classification.
`default_nettype none
module adp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire adp_pkg::item_t item,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output adp_pkg::cmd_t       cmd
);

  logic [adp_pkg::PosW-1:0] pos;
  logic [adp_pkg::PosW-1:0] pos_next;
  logic                     accept;

  assign item_ready = cmd_ready;
  assign cmd_valid  = item_valid;
  assign accept     = item_valid && cmd_ready;

  always_comb begin
    cmd.value    = item.byte_value;
    cmd.last     = item.last_byte;
    cmd.id_ok    = (item.byte_value == adp_pkg::id_byte(pos[2:0]));
    cmd.pos_lt9  = (pos < 11'd9);
    cmd.pos_lt17 = (pos < 11'd17);
    cmd.data_idx = pos - adp_pkg::DataOffset;
    priority if (pos < 11'd8) begin
      cmd.field = adp_pkg::FLD_ID;
    end else if (pos == 11'd8) begin
      cmd.field = adp_pkg::FLD_OP_LO;
    end else if (pos == 11'd9) begin
      cmd.field = adp_pkg::FLD_OP_HI;
    end else if (pos == 11'd12) begin
      cmd.field = adp_pkg::FLD_SEQ;
    end else if (pos == 11'd14) begin
      cmd.field = adp_pkg::FLD_UNI_LO;
    end else if (pos == 11'd15) begin
      cmd.field = adp_pkg::FLD_UNI_HI;
    end else if (pos == 11'd16) begin
      cmd.field = adp_pkg::FLD_LEN_HI;
    end else if (pos == 11'd17) begin
      cmd.field = adp_pkg::FLD_LEN_LO;
    end else if (pos >= adp_pkg::DataOffset) begin
      cmd.field = adp_pkg::FLD_DATA;
    end else begin
      cmd.field = adp_pkg::FLD_NONE;
    end
  end

  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (item.last_byte) begin
        pos_next = '0;
      end else if (pos != adp_pkg::PosMax) begin
        pos_next = pos + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/adp_queue.sv
// Short register FIFO carrying classified bytes from front to back.
`default_nettype none
module adp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire adp_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output adp_pkg::cmd_t      pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  adp_pkg::cmd_t   entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != Full);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/adp_back.sv
// Back end: header capture, channel write decision, summary and output register.
`default_nettype none
module adp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire adp_pkg::cmd_t     cmd,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output adp_pkg::result_t       result
);

  logic        id_matched, id_matched_next;
  logic [15:0] opcode_reg, opcode_next;
  logic [7:0]  sequence_reg, sequence_next;
  logic [15:0] universe_reg, universe_next;
  logic [15:0] length_reg, length_next;
  logic        pop;
  logic        len_ok;
  logic        wr;
  logic        hdr;
  adp_pkg::status_t st;
  adp_pkg::result_t res_next;

  assign cmd_ready = !result_valid || result_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    id_matched_next = id_matched;
    opcode_next     = opcode_reg;
    sequence_next   = sequence_reg;
    universe_next   = universe_reg;
    length_next     = length_reg;
    unique case (cmd.field)
      adp_pkg::FLD_ID:     id_matched_next = id_matched && cmd.id_ok;
      adp_pkg::FLD_OP_LO:  opcode_next     = {opcode_reg[15:8], cmd.value};
      adp_pkg::FLD_OP_HI:  opcode_next     = {cmd.value, opcode_reg[7:0]};
      adp_pkg::FLD_SEQ:    sequence_next   = cmd.value;
      adp_pkg::FLD_UNI_LO: universe_next   = {universe_reg[15:8], cmd.value};
      adp_pkg::FLD_UNI_HI: universe_next   = {cmd.value, universe_reg[7:0]};
      adp_pkg::FLD_LEN_HI: length_next     = {cmd.value, length_reg[7:0]};
      adp_pkg::FLD_LEN_LO: length_next     = {length_reg[15:8], cmd.value};
      default: ;
    endcase
  end

  assign len_ok = (length_next != 16'd0) && (length_next <= adp_pkg::MaxChannels);
  assign wr = (cmd.field == adp_pkg::FLD_DATA) && id_matched && len_ok &&
              (opcode_reg == adp_pkg::OpDmx) &&
              ({{(16 - adp_pkg::PosW){1'b0}}, cmd.data_idx} < length_reg);

  always_comb begin
    hdr = 1'b0;
    priority if (!id_matched_next) begin
      st = adp_pkg::ST_ID_BAD;
    end else if (cmd.pos_lt9) begin
      st = adp_pkg::ST_TRUNCATED;
    end else if (opcode_next == adp_pkg::OpDmx) begin
      if (cmd.pos_lt17) begin
        st = adp_pkg::ST_TRUNCATED;
      end else begin
        hdr = 1'b1;
        st  = len_ok ? adp_pkg::ST_DMX : adp_pkg::ST_BAD_LEN;
      end
    end else if (opcode_next == adp_pkg::OpPoll) begin
      st = adp_pkg::ST_POLL;
    end else begin
      st = adp_pkg::ST_OTHER_OP;
    end
  end

  always_comb begin
    res_next               = '0;
    res_next.write_valid   = wr;
    res_next.channel       = wr ? cmd.data_idx[8:0] : 9'd0;
    res_next.channel_value = wr ? cmd.value : 8'd0;
    if (cmd.last) begin
      res_next.packet_done = 1'b1;
      res_next.opcode      = (id_matched_next && !cmd.pos_lt9) ? opcode_next : 16'd0;
      res_next.universe    = hdr ? universe_next : 16'd0;
      res_next.sequence_res = hdr ? sequence_next : 8'd0;
      res_next.data_length = hdr ? length_next : 16'd0;
      res_next.status      = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_matched   <= 1'b1;
      opcode_reg   <= '0;
      sequence_reg <= '0;
      universe_reg <= '0;
      length_reg   <= '0;
    end else if (pop) begin
      if (cmd.last) begin
        id_matched   <= 1'b1;
        opcode_reg   <= '0;
        sequence_reg <= '0;
        universe_reg <= '0;
        length_reg   <= '0;
      end else begin
        id_matched   <= id_matched_next;
        opcode_reg   <= opcode_next;
        sequence_reg <= sequence_next;
        universe_reg <= universe_next;
        length_reg   <= length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= wr || cmd.last;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire
